// ===== rtl/core/vtpc_pkg.sv =====
// ----------------------------------------------------------------------------
// vtpc_pkg
// Shared types, constants and helpers for the vertex transform pipeline.
// ----------------------------------------------------------------------------
package vtpc_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOG_MULT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOG_OFFSET = 3'd5;

    localparam int H_W     = 50;   // homogeneous coordinate, s.16
    localparam int DIV_NW  = 64;   // dividend width
    localparam int DIV_DW  = 50;   // divisor width
    localparam int DIV_QW  = 31;   // quotient bits
    localparam int DIV_CW  = DIV_DW + DIV_QW;
    localparam int DIV_LAT = DIV_QW + 1;

    localparam logic [31:0]            INVW_NUM  = 32'h7FFF_FFFF;
    localparam logic signed [H_W-1:0]  W_MIN_RAW = 50'sd6553;
    localparam logic [17:0]            Q_CLAMP   = 18'h2_0000;

    typedef struct packed {
        logic [2:0]  neg;      // result sign per projection channel (x, y, fog)
        logic        w_zero;
        logic        w_neg;
        logic        d_neg;
        logic        d_zero;
        logic [15:0] clip_x;
        logic [15:0] clip_y;
        logic [15:0] clip_w;
        logic [5:0]  flags;
    } side_t;

    // integer part of a 34.16 magnitude, signed and saturated to 16 bits
    function automatic logic [15:0] sat_mag16(input logic [33:0] m, input logic neg);
        logic [15:0] r;
        if (neg)
            r = (m > 34'd32768) ? 16'h8000 : 16'(16'd0 - m[15:0]);
        else
            r = (m > 34'd32767) ? 16'h7FFF : m[15:0];
        return r;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [19:0] v);
        logic [15:0] r;
        if (v > 20'sd32767)
            r = 16'h7FFF;
        else if (v < -20'sd32768)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [19:0] v);
        logic [7:0] r;
        if (v < 20'sd0)
            r = 8'd0;
        else if (v > 20'sd255)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/vtpc_div.sv =====
// ----------------------------------------------------------------------------
// vtpc_div
// Pipelined restoring divider: one overflow check stage, then one quotient
// bit per stage. Quotient is valid when ovf is low.
// ----------------------------------------------------------------------------
module vtpc_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [vtpc_pkg::DIV_NW-1:0]  num,
    input  logic [vtpc_pkg::DIV_DW-1:0]  den,
    output logic [vtpc_pkg::DIV_QW-1:0]  quo,
    output logic                         ovf,
    output logic                         rem_nz
);

    localparam int NW = vtpc_pkg::DIV_NW;
    localparam int DW = vtpc_pkg::DIV_DW;
    localparam int QW = vtpc_pkg::DIV_QW;
    localparam int CW = vtpc_pkg::DIV_CW;

    logic [NW-1:0] rem_reg [0:QW];
    logic [QW-1:0] quo_reg [0:QW];
    logic          ovf_reg [0:QW];
    logic [DW-1:0] den_reg [0:QW-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            ovf_reg[0] <= ({{(CW-NW){1'b0}}, num} >= {den, {QW{1'b0}}});
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++)
        begin : g_step
            localparam int B = QW - k;
            logic [CW-1:0] sh;
            logic          ge;

            always_comb
            begin
                sh = {{QW{1'b0}}, den_reg[k-1]} << B;
                ge = ({{(CW-NW){1'b0}}, rem_reg[k-1]} >= sh);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? (rem_reg[k-1] - sh[NW-1:0]) : rem_reg[k-1];
                    quo_reg[k] <= quo_reg[k-1] | (ge ? (QW'(1) << B) : '0);
                    ovf_reg[k] <= ovf_reg[k-1];
                end
            end

            if (k < QW)
            begin : g_den
                always_ff @(posedge clk)
                begin
                    if (en)
                        den_reg[k] <= den_reg[k-1];
                end
            end
        end
    endgenerate

    assign quo    = quo_reg[QW];
    assign ovf    = ovf_reg[QW];
    assign rem_nz = (rem_reg[QW] != '0);

endmodule

// ===== rtl/core/vertex_transform_project_clip.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_project_clip
// 4x4 matrix transform, perspective divide, clip codes and fog per vertex.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | s_tvalid/s_tready  | s_tdata: index, value, x, y, z; s_tuser: func
//  output   | m_tvalid/m_tready  | m_tdata: screen, clip, inverse_w, fog, flags
//  config   | cfg_wen            | cfg_index, cfg_wdata
//
// One transaction per cycle while s_tready is high; a vertex result passes
// the 32-stage dividers (overflow check, then one quotient bit per stage).
// Matrix loads write at the accepting edge and produce no result.
// Reset clears the matrix, the configuration registers and all valid bits.
// A stall freezes the whole pipeline; a skid register behind the output lets
// one more result in, and s_tready drops only while the skid is occupied.
// ----------------------------------------------------------------------------
module vertex_transform_project_clip (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [3:0] element_index, [35:4] element_value, [51:36] coord_x,
    // [67:52] coord_y, [83:68] coord_z
    input  logic [87:0]  s_tdata,
    // [0] func
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] screen_x, [31:16] screen_y, [47:32] clip_x, [63:48] clip_y,
    // [79:64] clip_w, [111:80] inverse_w, [119:112] fog_level, [125:120] clip_flags
    output logic [127:0] m_tdata,
    input  logic         cfg_wen,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);

    localparam int HW  = vtpc_pkg::H_W;
    localparam int LAT = vtpc_pkg::DIV_LAT;
    localparam int QW  = vtpc_pkg::DIV_QW;

    // ---------------- configuration and matrix ----------------
    logic signed [15:0] scale_x_reg, scale_y_reg, trans_x_reg, trans_y_reg;
    logic signed [15:0] fog_mult_reg, fog_offset_reg;
    logic signed [31:0] mat_reg [0:15];

    logic adv, in_acc, vert_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg    <= '0;
            scale_y_reg    <= '0;
            trans_x_reg    <= '0;
            trans_y_reg    <= '0;
            fog_mult_reg   <= '0;
            fog_offset_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                vtpc_pkg::CFG_SCALE_X:    scale_x_reg    <= cfg_wdata;
                vtpc_pkg::CFG_SCALE_Y:    scale_y_reg    <= cfg_wdata;
                vtpc_pkg::CFG_TRANS_X:    trans_x_reg    <= cfg_wdata;
                vtpc_pkg::CFG_TRANS_Y:    trans_y_reg    <= cfg_wdata;
                vtpc_pkg::CFG_FOG_MULT:   fog_mult_reg   <= cfg_wdata;
                vtpc_pkg::CFG_FOG_OFFSET: fog_offset_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= '0;
        end
        else if (in_acc && s_tuser[0])
        begin
            mat_reg[s_tdata[3:0]] <= s_tdata[35:4];
        end
    end

    // ---------------- output buffer control ----------------
    logic         out_valid_reg, skid_valid_reg;
    logic [127:0] out_data_reg, skid_data_reg;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign in_acc   = s_tvalid && s_tready;
    assign vert_acc = in_acc && !s_tuser[0];

    // ---------------- stage A: element products ----------------
    logic signed [15:0] coord [0:2];
    logic signed [47:0] pa_next [0:3][0:2];
    logic signed [47:0] pa_reg  [0:3][0:2];
    logic signed [31:0] ta_reg  [0:3];
    logic               va_reg;

    assign coord[0] = s_tdata[51:36];
    assign coord[1] = s_tdata[67:52];
    assign coord[2] = s_tdata[83:68];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 3; r++)
                pa_next[c][r] = 48'(coord[r]) * 48'(mat_reg[r*4+c]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                ta_reg[c] <= mat_reg[12+c];
                for (int r = 0; r < 3; r++)
                    pa_reg[c][r] <= pa_next[c][r];
            end
        end
    end

    // ---------------- stage B: homogeneous sums ----------------
    logic signed [HW-1:0] h_reg [0:3];
    logic                 vb_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
                h_reg[c] <= HW'(ta_reg[c]) + HW'(pa_reg[c][0])
                          + HW'(pa_reg[c][1]) + HW'(pa_reg[c][2]);
        end
    end

    // ---------------- stage C: magnitudes, signs, clip codes ----------------
    logic [HW-1:0]        mag_next [0:3];
    logic [HW-1:0]        mag_reg  [0:3];
    logic signed [55:0]   h31_next, h31_reg;
    logic signed [HW:0]   neg_w;
    logic [5:0]           flags_next, flags_c_reg;
    logic [2:0]           neg_next, neg_c_reg;
    logic                 hneg_c_reg [0:3];
    logic                 wzero_c_reg, wneg_c_reg, vc_reg;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
            mag_next[c] = h_reg[c][HW-1] ? HW'(-h_reg[c]) : HW'(h_reg[c]);
        h31_next = (56'(h_reg[3]) <<< 5) - 56'(h_reg[3]);
        neg_w    = -(HW+1)'(h_reg[3]);
        flags_next = { ((HW+1)'(h_reg[1]) < neg_w),
                       ((HW+1)'(h_reg[0]) < neg_w),
                       1'b0,
                       (h_reg[3] <= vtpc_pkg::W_MIN_RAW),
                       (h_reg[1] > h_reg[3]),
                       (h_reg[0] > h_reg[3]) };
        neg_next[0] = h_reg[0][HW-1] ^ scale_x_reg[15]  ^ h_reg[3][HW-1];
        neg_next[1] = h_reg[1][HW-1] ^ scale_y_reg[15]  ^ h_reg[3][HW-1];
        neg_next[2] = h_reg[2][HW-1] ^ fog_mult_reg[15] ^ h_reg[3][HW-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mag_reg[c]    <= mag_next[c];
                hneg_c_reg[c] <= h_reg[c][HW-1];
            end
            h31_reg     <= h31_next;
            flags_c_reg <= flags_next;
            neg_c_reg   <= neg_next;
            wzero_c_reg <= (h_reg[3] == '0);
            wneg_c_reg  <= h_reg[3][HW-1];
        end
    end

    // ---------------- stage D: partial products, reciprocal divisor ----------------
    logic [15:0]  umul [0:2];
    logic [40:0]  lo_reg [0:2];
    logic [40:0]  hi_reg [0:2];
    logic [55:0]  h31_abs;
    logic [38:0]  dmag_reg;
    logic [HW-1:0] wmag_d_reg;
    logic         dneg_d_reg, dzero_next, dzero_d_reg, vd_reg;
    logic [15:0]  clip_d_reg [0:2];
    logic [5:0]   flags_d_reg;
    logic [2:0]   neg_d_reg;
    logic         wzero_d_reg, wneg_d_reg;

    always_comb
    begin
        umul[0] = scale_x_reg[15]  ? 16'(-scale_x_reg)  : scale_x_reg;
        umul[1] = scale_y_reg[15]  ? 16'(-scale_y_reg)  : scale_y_reg;
        umul[2] = fog_mult_reg[15] ? 16'(-fog_mult_reg) : fog_mult_reg;
        h31_abs = h31_reg[55] ? 56'(-h31_reg) : 56'(h31_reg);
        dzero_next = (h31_abs[54:16] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                lo_reg[j] <= 41'(mag_reg[j][24:0])    * 41'(umul[j]);
                hi_reg[j] <= 41'(mag_reg[j][HW-1:25]) * 41'(umul[j]);
            end
            clip_d_reg[0] <= vtpc_pkg::sat_mag16(mag_reg[0][HW-1:16], hneg_c_reg[0]);
            clip_d_reg[1] <= vtpc_pkg::sat_mag16(mag_reg[1][HW-1:16], hneg_c_reg[1]);
            clip_d_reg[2] <= vtpc_pkg::sat_mag16(mag_reg[3][HW-1:16], hneg_c_reg[3]);
            dmag_reg    <= h31_abs[54:16];
            dneg_d_reg  <= h31_reg[55];
            dzero_d_reg <= dzero_next;
            wmag_d_reg  <= mag_reg[3];
            flags_d_reg <= flags_c_reg;
            neg_d_reg   <= neg_c_reg;
            wzero_d_reg <= wzero_c_reg;
            wneg_d_reg  <= wneg_c_reg;
        end
    end

    // ---------------- stage E: full products ----------------
    logic [63:0]        prod_reg [0:2];
    logic [HW-1:0]      wmag_e_reg;
    logic [38:0]        dmag_e_reg;
    vtpc_pkg::side_t    side_e_reg;
    logic               ve_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
                prod_reg[j] <= (64'(hi_reg[j]) << 25) + 64'(lo_reg[j]);
            wmag_e_reg        <= wmag_d_reg;
            dmag_e_reg        <= dmag_reg;
            side_e_reg.neg    <= neg_d_reg;
            side_e_reg.w_zero <= wzero_d_reg;
            side_e_reg.w_neg  <= wneg_d_reg;
            side_e_reg.d_neg  <= dneg_d_reg;
            side_e_reg.d_zero <= dzero_d_reg;
            side_e_reg.clip_x <= clip_d_reg[0];
            side_e_reg.clip_y <= clip_d_reg[1];
            side_e_reg.clip_w <= clip_d_reg[2];
            side_e_reg.flags  <= flags_d_reg;
        end
    end

    // ---------------- dividers ----------------
    logic [QW-1:0] quo  [0:3];
    logic          ovf  [0:3];
    logic          rnz  [0:3];

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_proj_div
            vtpc_div u_div (
                .clk    (clk),
                .en     (adv),
                .num    (prod_reg[g]),
                .den    (wmag_e_reg),
                .quo    (quo[g]),
                .ovf    (ovf[g]),
                .rem_nz (rnz[g])
            );
        end
    endgenerate

    vtpc_div u_inv_div (
        .clk    (clk),
        .en     (adv),
        .num    (64'(vtpc_pkg::INVW_NUM)),
        .den    (HW'(dmag_e_reg)),
        .quo    (quo[3]),
        .ovf    (ovf[3]),
        .rem_nz (rnz[3])
    );

    vtpc_pkg::side_t side_reg [0:LAT-1];
    logic            sv_reg   [0:LAT-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_e_reg;
            for (int i = 1; i < LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // ---------------- stage P1: signed quotient and base add ----------------
    logic signed [15:0] base [0:2];
    logic [17:0]        qc   [0:2];
    logic               clamp [0:2];
    logic signed [18:0] fl   [0:2];
    logic signed [19:0] t_reg [0:2];
    logic               rnz_p1_reg [0:2];
    logic [31:0]        inv_next, inv_p1_reg;
    vtpc_pkg::side_t    side_p1_reg;
    logic               p1v_reg;

    assign base[0] = trans_x_reg;
    assign base[1] = trans_y_reg;
    assign base[2] = fog_offset_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            clamp[j] = ovf[j] || (quo[j][QW-1:17] != '0);
            qc[j]    = clamp[j] ? vtpc_pkg::Q_CLAMP : {1'b0, quo[j][16:0]};
            if (!side_reg[LAT-1].neg[j])
                fl[j] = $signed({1'b0, qc[j]});
            else if (clamp[j])
                fl[j] = -19'sd131072;
            else
                fl[j] = -$signed({1'b0, qc[j]}) - $signed({18'b0, rnz[j]});
        end
        if (side_reg[LAT-1].d_zero)
            inv_next = vtpc_pkg::INVW_NUM;
        else if (side_reg[LAT-1].d_neg)
            inv_next = 32'(-{1'b0, quo[3]});
        else
            inv_next = {1'b0, quo[3]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                t_reg[j]      <= 20'(base[j]) + 20'(fl[j]);
                rnz_p1_reg[j] <= rnz[j] && !clamp[j];
            end
            inv_p1_reg  <= inv_next;
            side_p1_reg <= side_reg[LAT-1];
        end
    end

    // ---------------- stage P2: rounding fix and saturation ----------------
    logic signed [19:0] t2 [0:2];
    logic [127:0]       res_next, res_reg;
    logic [15:0]        scr_x, scr_y;
    logic [7:0]         fog;
    logic               p2v_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            t2[j] = t_reg[j] + 20'((t_reg[j] < 20'sd0) && rnz_p1_reg[j]);
        scr_x = side_p1_reg.w_zero ? trans_x_reg : vtpc_pkg::sat16(t2[0]);
        scr_y = side_p1_reg.w_zero ? trans_y_reg : vtpc_pkg::sat16(t2[1]);
        if (side_p1_reg.w_neg)
            fog = 8'd0;
        else if (side_p1_reg.w_zero)
            fog = vtpc_pkg::clamp8(20'(fog_offset_reg));
        else
            fog = vtpc_pkg::clamp8(t2[2]);
        res_next = {2'b00, side_p1_reg.flags, fog, inv_p1_reg, side_p1_reg.clip_w,
                    side_p1_reg.clip_y, side_p1_reg.clip_x, scr_y, scr_x};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            vc_reg  <= 1'b0;
            vd_reg  <= 1'b0;
            ve_reg  <= 1'b0;
            p1v_reg <= 1'b0;
            p2v_reg <= 1'b0;
            for (int i = 0; i < LAT; i++)
                sv_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            va_reg    <= vert_acc;
            vb_reg    <= va_reg;
            vc_reg    <= vb_reg;
            vd_reg    <= vc_reg;
            ve_reg    <= vd_reg;
            sv_reg[0] <= ve_reg;
            for (int i = 1; i < LAT; i++)
                sv_reg[i] <= sv_reg[i-1];
            p1v_reg   <= sv_reg[LAT-1];
            p2v_reg   <= p1v_reg;
        end
    end

    // ---------------- output register and skid ----------------
    logic push, pop;

    assign push = adv && p2v_reg;
    assign pop  = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !out_valid_reg)
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_reg;
        else if (push)
            skid_data_reg <= res_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_vertex_enters: assert property (@(posedge clk) disable iff (!rst_n)
        vert_acc |=> va_reg)
        else $error("accepted vertex did not enter the pipeline");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tuser[0]) |=> !va_reg)
        else $error("matrix load entered the result pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(p2v_reg) && $stable(sv_reg[LAT-1])))
        else $error("pipeline moved during a stall");

endmodule
